// File: sv/uidst_pkg.sv
// ----------------------------------------------------------------------------
// uidst_pkg
// Shared opcodes, status codes and the result beat type for the unique ID
// set table.
// ----------------------------------------------------------------------------
package uidst_pkg;

  // operation codes on the request channel
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_RM_INDEX = 3'd2,
    OP_RM_VALUE = 3'd3,
    OP_GET      = 3'd4,
    OP_SET      = 3'd5
  } op_t;

  // status codes on the response channel
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // one response beat
  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [5:0]  found_position;
    logic [6:0]  fill_count;
  } rsp_t;

endpackage

// File: sv/uidst_out_reg.sv
// ----------------------------------------------------------------------------
// uidst_out_reg
// Response holding register: keeps one finished beat until the receiver
// takes it, and frees itself in the same cycle it is drained.
// ----------------------------------------------------------------------------
module uidst_out_reg
  import uidst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  output logic load_ready,
  input  rsp_t load_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  logic full;
  rsp_t data;

  // free when empty or when the held beat leaves this cycle
  assign load_ready = !full || rsp_ready;
  assign rsp_valid  = full;
  assign rsp_data   = data;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load_valid && load_ready) begin
      full <= 1'b1;
    end else if (rsp_ready) begin
      full <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data <= load_data;
    end
  end

endmodule

// File: sv/unique_id_set_table.sv
// ----------------------------------------------------------------------------
// unique_id_set_table
// Ordered list of unique 32-bit IDs held in one synchronous memory with a
// fill count; add, contains, remove by index or value, get and set.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries opcode, slot_index and
//   id_value; response channel (rsp_valid/rsp_ready) returns status,
//   read_value, found_position and fill_count, one response beat per request.
//   One request is in work at a time. The memory has one read and one write
//   port with a registered read, so the walks run one entry per cycle. Get,
//   set, unused opcodes and range errors need no walk; add and contains
//   scan until a hit, a miss scans every used entry, remove at index pulls
//   the later entries down, and remove value on a hit scans, then shifts.
//   After reset the block sweeps the memory to zero with req_ready low,
//   then starts empty.
//   A finished beat sits in an output register; if the receiver stalls, the
//   next request is still accepted and worked on, and waits only to hand
//   over its own response.
// ----------------------------------------------------------------------------
module unique_id_set_table
  import uidst_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         opcode,
  input  logic [5:0]         slot_index,
  input  logic signed [31:0] id_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic [5:0]         found_position,
  output logic [6:0]         fill_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_GET,
    S_RESP
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [2:0]    op_q;
  logic [31:0]   val_q;
  logic [CW-1:0] ptr;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] base;
  status_t       status_q;
  logic [31:0]   rd_q;
  logic [5:0]    pos_q;

  // id store
  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic          we;

  // helpers
  logic [31:0]   idx_w;
  logic [31:0]   cnt_w;
  logic [31:0]   pend_w;
  logic          idx_in_cap;
  logic          idx_in_fill;
  logic          issue;
  logic          hit;
  logic          at_cap;
  logic          req_acc;
  logic          load_ready;
  rsp_t          load_data;
  rsp_t          rsp_data;

  assign idx_w       = 32'(slot_index);
  assign cnt_w       = 32'(cnt);
  assign pend_w      = 32'(pend_addr);
  assign idx_in_cap  = idx_w < 32'(CAPACITY);
  assign idx_in_fill = idx_w < cnt_w;
  assign issue       = ptr < cnt;
  assign hit         = pend && (rd_data == val_q);
  assign at_cap      = cnt == CW'(CAPACITY);
  assign req_ready   = state == S_IDLE;
  assign req_acc     = req_valid && req_ready;

  // memory port control
  always_comb begin
    ra = ptr[AW-1:0];
    wa = ptr[AW-1:0];
    wd = '0;
    we = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        ra = idx_w[AW-1:0];
        wa = idx_w[AW-1:0];
        wd = id_value;
        we = req_acc && (op_t'(opcode) == OP_SET) && idx_in_cap;
      end
      S_SCAN: begin
        // append after a miss
        wa = cnt[AW-1:0];
        wd = val_q;
        we = !hit && !pend && !issue && (op_t'(op_q) == OP_ADD) && !at_cap;
      end
      S_SHIFT: begin
        // move the entry read last cycle one place down
        wa = pend_addr - AW'(1);
        wd = rd_data;
        we = pend && (pend_addr != base);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      ptr      <= '0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        // zero sweep after reset
        S_CLEAR: begin
          if (ptr == CW'(CAPACITY - 1)) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + CW'(1);
          end
        end

        // decode a new request
        S_IDLE: begin
          if (req_acc) begin
            op_q     <= opcode;
            val_q    <= id_value;
            status_q <= ST_OK;
            rd_q     <= '0;
            pos_q    <= '0;
            ptr      <= '0;
            pend     <= 1'b0;
            unique case (op_t'(opcode))
              OP_ADD, OP_CONTAINS, OP_RM_VALUE: begin
                state <= S_SCAN;
              end
              OP_RM_INDEX: begin
                if (idx_in_fill) begin
                  ptr   <= idx_w[CW-1:0];
                  base  <= idx_w[AW-1:0];
                  state <= S_SHIFT;
                end else begin
                  status_q <= ST_RANGE;
                  state    <= S_RESP;
                end
              end
              OP_GET: begin
                if (idx_in_cap) begin
                  state <= S_GET;
                end else begin
                  status_q <= ST_RANGE;
                  state    <= S_RESP;
                end
              end
              OP_SET: begin
                if (!idx_in_cap) begin
                  status_q <= ST_RANGE;
                end
                state <= S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end

        // linear search over the used entries
        S_SCAN: begin
          if (hit) begin
            pend <= 1'b0;
            unique case (op_t'(op_q))
              OP_CONTAINS: begin
                pos_q <= pend_w[5:0];
                state <= S_RESP;
              end
              OP_ADD: begin
                status_q <= ST_PRESENT;
                state    <= S_RESP;
              end
              default: begin
                ptr   <= pend_w[CW-1:0];
                base  <= pend_addr;
                state <= S_SHIFT;
              end
            endcase
          end else if (!pend && !issue) begin
            if (op_t'(op_q) == OP_ADD) begin
              if (at_cap) begin
                status_q <= ST_FULL;
              end else begin
                cnt <= cnt + CW'(1);
              end
            end else begin
              status_q <= ST_NOT_FOUND;
            end
            state <= S_RESP;
          end else begin
            pend      <= issue;
            pend_addr <= ptr[AW-1:0];
            if (issue) begin
              ptr <= ptr + CW'(1);
            end
          end
        end

        // read the removed entry, then pull later entries down
        S_SHIFT: begin
          if (pend && (pend_addr == base)) begin
            rd_q <= rd_data;
          end
          if (!pend && !issue) begin
            cnt   <= cnt - CW'(1);
            state <= S_RESP;
          end else begin
            pend      <= issue;
            pend_addr <= ptr[AW-1:0];
            if (issue) begin
              ptr <= ptr + CW'(1);
            end
          end
        end

        // read data of a get
        S_GET: begin
          rd_q  <= rd_data;
          state <= S_RESP;
        end

        // hand the beat to the output register
        S_RESP: begin
          if (load_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response beat
  always_comb begin
    load_data.status         = status_q;
    load_data.read_value     = rd_q;
    load_data.found_position = pos_q;
    load_data.fill_count     = cnt_w[6:0];
  end

  uidst_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (state == S_RESP),
    .load_ready (load_ready),
    .load_data  (load_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data)
  );

  assign status         = rsp_data.status;
  assign read_value     = rsp_data.read_value;
  assign found_position = rsp_data.found_position;
  assign fill_count     = rsp_data.fill_count;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("fill count moved by more than one");

  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && we) |-> (32'(wa) + 32'd1 < cnt_w))
    else $error("shift write outside the used entries");

  a_scan_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pend) |-> (pend_w < cnt_w))
    else $error("search compared an unused entry");

endmodule

// File: test/tb_unique_id_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_id_set_table
// Self-checking bench for the unique ID set table. A queue of requests
// (a directed opening, then phases of fill, drain and mixed traffic) feeds
// a valid/ready driver; a shadow copy of the table predicts every response
// beat, and the monitor compares each one field by field under random
// stalls, including one long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_unique_id_set_table;
  import uidst_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 200;
  localparam int HOLD_AT    = 600;
  localparam int HOLD_LEN   = 500;

  // opcodes the block leaves unused
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [31:0] id;
  } req_item_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [2:0]         opcode = '0;
  logic [5:0]         slot_index = '0;
  logic signed [31:0] id_value = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [5:0]         found_position;
  logic [6:0]         fill_count;

  unique_id_set_table #(.CAPACITY(DEPTH)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .opcode         (opcode),
    .slot_index     (slot_index),
    .id_value       (id_value),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .fill_count     (fill_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  req_item_t   op_q[$];
  rsp_t        answer_q[$];
  logic [31:0] shadow_ids[DEPTH];
  logic [6:0]  shadow_fill;
  logic [31:0] id_pool[DEPTH];
  int          pool_n;
  int          pool_wr;
  int          total_ops;
  int          sent;
  int          got;
  int          errors;
  int          idle_cycles;

  // shadow table: unlink entry at pos and close the gap
  function automatic logic [31:0] take_entry(int pos);
    logic [31:0] v;
    int i;
    v = shadow_ids[pos];
    for (i = pos; i + 1 < shadow_fill; i++) shadow_ids[i] = shadow_ids[i + 1];
    shadow_fill--;
    return v;
  endfunction

  // apply one request to the shadow table and form the response beat
  function automatic rsp_t apply_set_op(req_item_t r);
    rsp_t a;
    int hit;
    int i;
    a.status = ST_OK;
    a.read_value = '0;
    a.found_position = '0;
    hit = -1;
    for (i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_ids[i] == r.id) hit = i;
    end
    case (r.op)
      OP_ADD: begin
        if (hit >= 0) a.status = ST_PRESENT;
        else if (shadow_fill >= DEPTH) a.status = ST_FULL;
        else begin
          shadow_ids[shadow_fill] = r.id;
          shadow_fill++;
        end
      end
      OP_CONTAINS: begin
        if (hit >= 0) a.found_position = hit[5:0];
        else a.status = ST_NOT_FOUND;
      end
      OP_RM_INDEX: begin
        if (r.slot >= shadow_fill) a.status = ST_RANGE;
        else a.read_value = take_entry(r.slot);
      end
      OP_RM_VALUE: begin
        if (hit >= 0) a.read_value = take_entry(hit);
        else a.status = ST_NOT_FOUND;
      end
      OP_GET: begin
        if (r.slot < DEPTH) a.read_value = shadow_ids[r.slot];
        else a.status = ST_RANGE;
      end
      OP_SET: begin
        if (r.slot < DEPTH) shadow_ids[r.slot] = r.id;
        else a.status = ST_RANGE;
      end
      default: ;
    endcase
    a.fill_count = shadow_fill;
    return a;
  endfunction

  function automatic req_item_t mk(logic [2:0] op, logic [5:0] slot, logic [31:0] id);
    req_item_t r;
    r.op = op;
    r.slot = slot;
    r.id = id;
    return r;
  endfunction

  function automatic logic [2:0] pick_op(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 75) return OP_ADD;
        if (roll < 85) return OP_CONTAINS;
        if (roll < 90) return OP_GET;
        if (roll < 94) return OP_SET;
        if (roll < 97) return OP_RM_VALUE;
        return OP_RM_INDEX;
      end
      MIX_DRAIN: begin
        if (roll < 35) return OP_RM_INDEX;
        if (roll < 70) return OP_RM_VALUE;
        if (roll < 80) return OP_CONTAINS;
        if (roll < 88) return OP_GET;
        if (roll < 93) return OP_ADD;
        if (roll < 96) return OP_SET;
        return (roll < 98) ? OP_SPARE_A : OP_SPARE_B;
      end
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // random request; IDs are often reused so that hits and duplicates happen
  function automatic req_item_t make_item(mix_t mix);
    req_item_t r;
    int roll;
    bit fresh;
    r.op = pick_op(mix);
    r.slot = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 15))
                                          : 6'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    fresh = 1'b0;
    if (roll < 55 && pool_n > 0) r.id = id_pool[$urandom_range(0, pool_n - 1)];
    else if (roll < 58) r.id = 32'h8000_0000;
    else if (roll < 61) r.id = 32'h7fff_ffff;
    else if (roll < 63) r.id = 32'hffff_ffff;
    else if (roll < 65) r.id = 32'h0;
    else begin
      r.id = $urandom;
      fresh = 1'b1;
    end
    if (fresh && (r.op == OP_ADD || r.op == OP_SET)) begin
      id_pool[pool_wr] = r.id;
      pool_wr = (pool_wr + 1) % DEPTH;
      if (pool_n < DEPTH) pool_n++;
    end
    return r;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  req_item_t cur_item;
  bit        offering;
  bit        tx_quiet;
  int        tx_gap;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
      tx_quiet = 1'b0;
    end else begin
      offering = req_valid;
      if (req_valid && req_ready) begin
        answer_q.push_back(apply_set_op(cur_item));
        sent++;
        if (sent % 150 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
        tx_gap = pick_gap(tx_quiet);
        offering = 1'b0;
      end
      if (!offering) begin
        if (tx_gap > 0) tx_gap--;
        else if (op_q.size() > 0) begin
          cur_item = op_q.pop_front();
          offering = 1'b1;
        end
      end
      req_valid  <= offering;
      opcode     <= cur_item.op;
      slot_index <= cur_item.slot;
      id_value   <= cur_item.id;
    end
  end

  // response monitor and receiver stalls
  bit rx_quiet;
  int rx_gap;
  int rx_hold;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_gap = 0;
      rx_hold = 0;
      rx_quiet = 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response beat: status=%0d", status);
        end else begin
          rsp_t want;
          want = answer_q.pop_front();
          if (want.status != status || want.read_value != read_value ||
              want.found_position != found_position || want.fill_count != fill_count) begin
            errors++;
            if (errors <= 10)
              $display("beat %0d mismatch: exp st=%0d rd=%h pos=%0d fill=%0d, got st=%0d rd=%h pos=%0d fill=%0d",
                       got, want.status, want.read_value, want.found_position,
                       want.fill_count, status, read_value, found_position, fill_count);
          end
        end
        got++;
        if (got % 170 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        rx_gap = pick_gap(rx_quiet);
        // one long hold-off so the request side backs up
        if (got == HOLD_AT) rx_hold = HOLD_LEN;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus build, reset and end of run
  initial begin
    mix_t mix;
    int ph;
    int k;
    shadow_fill = '0;
    foreach (shadow_ids[i]) shadow_ids[i] = '0;
    pool_n = 0;
    pool_wr = 0;
    sent = 0;
    got = 0;
    errors = 0;
    idle_cycles = 0;

    // directed: empty table, extremes, duplicates, stale slot, spare opcodes
    op_q.push_back(mk(OP_GET,      6'd0,  32'h0));
    op_q.push_back(mk(OP_CONTAINS, 6'd0,  32'h0));
    op_q.push_back(mk(OP_RM_INDEX, 6'd0,  32'h0));
    op_q.push_back(mk(OP_RM_VALUE, 6'd0,  32'h5));
    op_q.push_back(mk(OP_ADD,      6'd0,  32'h8000_0000));
    op_q.push_back(mk(OP_ADD,      6'd63, 32'h7fff_ffff));
    op_q.push_back(mk(OP_ADD,      6'd0,  32'h8000_0000));
    op_q.push_back(mk(OP_ADD,      6'd0,  32'h0));
    op_q.push_back(mk(OP_ADD,      6'd0,  32'hffff_ffff));
    op_q.push_back(mk(OP_CONTAINS, 6'd0,  32'hffff_ffff));
    op_q.push_back(mk(OP_RM_INDEX, 6'd63, 32'h0));
    op_q.push_back(mk(OP_SET,      6'd63, 32'h1234_5678));
    op_q.push_back(mk(OP_GET,      6'd63, 32'h0));
    op_q.push_back(mk(OP_SET,      6'd1,  32'h8000_0000));
    op_q.push_back(mk(OP_CONTAINS, 6'd0,  32'h8000_0000));
    op_q.push_back(mk(OP_RM_VALUE, 6'd0,  32'h8000_0000));
    op_q.push_back(mk(OP_GET,      6'd3,  32'h0));
    op_q.push_back(mk(OP_RM_INDEX, 6'd2,  32'h0));
    op_q.push_back(mk(OP_RM_INDEX, 6'd0,  32'h0));
    op_q.push_back(mk(OP_SPARE_A,  6'd63, 32'hffff_ffff));
    op_q.push_back(mk(OP_SPARE_B,  6'd21, 32'h5555_aaaa));
    op_q.push_back(mk(OP_RM_VALUE, 6'd0,  32'h0));
    op_q.push_back(mk(OP_GET,      6'd63, 32'h0));

    // random phases; every third one fills the table toward full
    for (ph = 0; ph < 18; ph++) begin
      mix = (ph % 3 == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      for (k = 0; k < 100; k++) op_q.push_back(make_item(mix));
    end
    total_ops = op_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (sent == total_ops);
    wait (answer_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
